@@ hdl/hsv_to_rgb_converter_defines.svh @@
// Assertion macros shared by the converter RTL; clock is clock, reset is reset.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HSVC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HSVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/hsvc_pkg.sv @@
// Types, constants and helpers shared by the HSV to RGB converter.
package hsvc_pkg;

   localparam int HUE_BITS    = 11;
   localparam int FRAC_BITS   = 8;
   localparam int SECTOR_BITS = HUE_BITS - FRAC_BITS;
   localparam int IN_BITS     = 8;
   localparam int OUT_BITS    = 8;
   localparam logic [FRAC_BITS:0]     FRAC_ONE    = 9'd256;
   localparam logic [SECTOR_BITS-1:0] SECTOR_WRAP = 3'd6;

   typedef enum logic [SECTOR_BITS-1:0] {
      SECT_RED     = 3'd0,
      SECT_YELLOW  = 3'd1,
      SECT_GREEN   = 3'd2,
      SECT_CYAN    = 3'd3,
      SECT_BLUE    = 3'd4,
      SECT_MAGENTA = 3'd5
   } hsvc_sector_type;

   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      logic [IN_BITS-1:0]  saturation;
      logic [IN_BITS-1:0]  brightness;
   } hsvc_req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] red;
      logic [OUT_BITS-1:0] green;
      logic [OUT_BITS-1:0] blue;
   } hsvc_rsp_type;

   // Load enables for the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } hsvc_adv_type;

   // Sectors past the last one wrap round the hue circle.
   function automatic hsvc_sector_type hsvc_wrap_sector(input logic [SECTOR_BITS-1:0] raw);
      hsvc_sector_type sect;
      if (raw >= SECTOR_WRAP) begin
         sect = hsvc_sector_type'(raw - SECTOR_WRAP);
      end else begin
         sect = hsvc_sector_type'(raw);
      end
      return sect;
   endfunction

endpackage

@@ hdl/hsvc_level.sv @@
// Stages one and two: saturation products, then brightness products.
module hsvc_level #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                          clock,
   input  hsvc_pkg::hsvc_adv_type        adv,
   input  hsvc_pkg::hsvc_req_type        req_data,
   output logic [CHANNEL_BITS-1:0]       v_out,
   output hsvc_pkg::hsvc_sector_type     sector_out,
   output logic                          grey_out,
   output logic [2*CHANNEL_BITS-1:0]     p_prod,
   output logic [2*CHANNEL_BITS+7:0]     q_prod,
   output logic [2*CHANNEL_BITS+7:0]     t_prod
);
   import hsvc_pkg::*;

   localparam int W  = CHANNEL_BITS;
   localparam int WF = CHANNEL_BITS + FRAC_BITS;
   localparam logic [W-1:0]  CH_MAX = {W{1'b1}};
   localparam logic [WF-1:0] FULL   = WF'(CH_MAX) << FRAC_BITS;

   logic [W-1:0]          s_in;
   logic [W-1:0]          v1_in, v1_ff;
   logic [W-1:0]          ms1_in, ms1_ff;
   logic [WF-1:0]         sf1_in, sf1_ff;
   logic [WF-1:0]         sg1_in, sg1_ff;
   logic [FRAC_BITS-1:0]  frac;
   logic [FRAC_BITS:0]    frac_rest;
   hsvc_sector_type       sector1_in, sector1_ff;
   logic                  grey1_in, grey1_ff;

   logic [WF-1:0]         nq, nt;
   logic [2*W-1:0]        pp2_in, pp2_ff;
   logic [2*W+7:0]        pq2_in, pq2_ff;
   logic [2*W+7:0]        pt2_in, pt2_ff;
   logic [W-1:0]          v2_ff;
   hsvc_sector_type       sector2_ff;
   logic                  grey2_ff;

   always_comb begin
      s_in       = W'(req_data.saturation);
      v1_in      = W'(req_data.brightness);
      frac       = req_data.hue[FRAC_BITS-1:0];
      frac_rest  = FRAC_ONE - {1'b0, frac};
      ms1_in     = CH_MAX - s_in;
      sf1_in     = WF'(s_in) * WF'(frac);
      sg1_in     = WF'(s_in) * WF'(frac_rest);
      sector1_in = hsvc_wrap_sector(req_data.hue[HUE_BITS-1:FRAC_BITS]);
      grey1_in   = (s_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         v1_ff      <= v1_in;
         ms1_ff     <= ms1_in;
         sf1_ff     <= sf1_in;
         sg1_ff     <= sg1_in;
         sector1_ff <= sector1_in;
         grey1_ff   <= grey1_in;
      end
   end

   always_comb begin
      nq     = FULL - sf1_ff;
      nt     = FULL - sg1_ff;
      pp2_in = (2*W)'(v1_ff) * (2*W)'(ms1_ff);
      pq2_in = (2*W+8)'(v1_ff) * (2*W+8)'(nq);
      pt2_in = (2*W+8)'(v1_ff) * (2*W+8)'(nt);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         v2_ff      <= v1_ff;
         sector2_ff <= sector1_ff;
         grey2_ff   <= grey1_ff;
         pp2_ff     <= pp2_in;
         pq2_ff     <= pq2_in;
         pt2_ff     <= pt2_in;
      end
   end

   assign v_out      = v2_ff;
   assign sector_out = sector2_ff;
   assign grey_out   = grey2_ff;
   assign p_prod     = pp2_ff;
   assign q_prod     = pq2_ff;
   assign t_prod     = pt2_ff;

endmodule

@@ hdl/hsvc_recip_div.sv @@
// Divide by full scale (2^N - 1): fold the high half, register, then correct.
module hsvc_recip_div #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic [2*CHANNEL_BITS-1:0] num,
   output logic [CHANNEL_BITS-1:0]   quo
);
   import hsvc_pkg::*;

   localparam int W = CHANNEL_BITS;
   localparam logic [W:0] CH_MAX = {1'b0, {W{1'b1}}};
   localparam logic [W:0] TWICE  = {{W{1'b1}}, 1'b0};

   logic [W-1:0] est_in, est_ff;
   logic [W:0]   rem_in, rem_ff;
   logic [W:0]   quo_wide;

   // num = est * 2^N + low, so num - est * M = low + est (at most 2M here)
   always_comb begin
      est_in = num[2*W-1:W];
      rem_in = {1'b0, num[W-1:0]} + {1'b0, est_in};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         est_ff <= est_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      quo_wide = {1'b0, est_ff} + (W+1)'(rem_ff >= CH_MAX) + (W+1)'(rem_ff >= TWICE);
      quo      = quo_wide[W-1:0];
   end

endmodule

@@ hdl/hsv_to_rgb_converter.sv @@
// HSV to RGB pixel converter: four-stage pipeline, one pixel per clock.
// Takes one pixel per clock when nothing stalls and returns it from the fourth stage.
// Stage one forms saturation times the sector fraction, stage two multiplies the
// levels by brightness, stage three folds each level for the divide by full scale,
// and stage four corrects the quotients and routes them through the sector mux
// into the output register. Each stage loads whenever it is empty or the stage
// after it moves, so a stalled output still lets new pixels fill empty stages.
`include "hsv_to_rgb_converter_defines.svh"
module hsv_to_rgb_converter #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hsvc_pkg::hsvc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hsvc_pkg::hsvc_rsp_type rsp_data
);
   import hsvc_pkg::*;

   localparam int W = CHANNEL_BITS;
   localparam logic [2*W-1:0] HALF_MAX = (2*W)'({W{1'b1}}) >> 1;
   localparam logic [2*W+7:0] QT_ROUND = (2*W+8)'({W{1'b1}}) << (FRAC_BITS - 1);

   hsvc_adv_type    adv;
   logic            valid1_ff, valid2_ff, valid3_ff, rsp_valid_ff;

   logic [W-1:0]    v2;
   hsvc_sector_type sector2;
   logic            grey2;
   logic [2*W-1:0]  p_prod;
   logic [2*W+7:0]  q_prod, t_prod;
   logic [2*W-1:0]  p_num;
   logic [2*W+7:0]  q_sum, t_sum;

   logic [W-1:0]    v3_ff;
   hsvc_sector_type sector3_ff;
   logic            grey3_ff;
   logic [W-1:0]    p_quo, q_quo, t_quo;
   logic [OUT_BITS-1:0] v3_out, p_out, q_out, t_out;
   hsvc_rsp_type    rsp_in, rsp_ff;

   // Stage loads when empty or when the next stage takes its word.
   always_comb begin
      adv.s4 = !rsp_valid_ff || rsp_ready;
      adv.s3 = !valid3_ff || adv.s4;
      adv.s2 = !valid2_ff || adv.s3;
      adv.s1 = !valid1_ff || adv.s2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv.s1) begin
            valid1_ff <= req_valid;
         end
         if (adv.s2) begin
            valid2_ff <= valid1_ff;
         end
         if (adv.s3) begin
            valid3_ff <= valid2_ff;
         end
         if (adv.s4) begin
            rsp_valid_ff <= valid3_ff;
         end
      end
   end

   hsvc_level #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_level (
      .clock     (clock),
      .adv       (adv),
      .req_data  (req_data),
      .v_out     (v2),
      .sector_out(sector2),
      .grey_out  (grey2),
      .p_prod    (p_prod),
      .q_prod    (q_prod),
      .t_prod    (t_prod)
   );

   // Round to nearest; q and t drop the fraction scale before the divide.
   always_comb begin
      p_num = p_prod + HALF_MAX;
      q_sum = q_prod + QT_ROUND;
      t_sum = t_prod + QT_ROUND;
   end

   hsvc_recip_div #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_div_p (
      .clock(clock),
      .load (adv.s3),
      .num  (p_num),
      .quo  (p_quo)
   );

   hsvc_recip_div #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_div_q (
      .clock(clock),
      .load (adv.s3),
      .num  (q_sum[2*W+7:FRAC_BITS]),
      .quo  (q_quo)
   );

   hsvc_recip_div #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_div_t (
      .clock(clock),
      .load (adv.s3),
      .num  (t_sum[2*W+7:FRAC_BITS]),
      .quo  (t_quo)
   );

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         v3_ff      <= v2;
         sector3_ff <= sector2;
         grey3_ff   <= grey2;
      end
   end

   always_comb begin
      v3_out = OUT_BITS'(v3_ff);
      p_out  = OUT_BITS'(p_quo);
      q_out  = OUT_BITS'(q_quo);
      t_out  = OUT_BITS'(t_quo);
      if (grey3_ff) begin
         rsp_in = '{red: v3_out, green: v3_out, blue: v3_out};
      end else begin
         case (sector3_ff)
            SECT_RED:    rsp_in = '{red: v3_out, green: t_out,  blue: p_out};
            SECT_YELLOW: rsp_in = '{red: q_out,  green: v3_out, blue: p_out};
            SECT_GREEN:  rsp_in = '{red: p_out,  green: v3_out, blue: t_out};
            SECT_CYAN:   rsp_in = '{red: p_out,  green: q_out,  blue: v3_out};
            SECT_BLUE:   rsp_in = '{red: t_out,  green: p_out,  blue: v3_out};
            default:     rsp_in = '{red: v3_out, green: p_out,  blue: q_out};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = adv.s1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `HSVC_ASSERT_NOW(a_full_blocks_input, valid1_ff && valid2_ff && valid3_ff && rsp_valid_ff && !rsp_ready, !req_ready, "full pipeline with stalled output still accepts a word")
   `HSVC_ASSERT_NEXT(a_grey_equal, adv.s4 && valid3_ff && grey3_ff, rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue, "zero saturation word is not grey")
   `HSVC_ASSERT_NEXT(a_one_channel_is_v, adv.s4 && valid3_ff, rsp_data.red == $past(v3_out) || rsp_data.green == $past(v3_out) || rsp_data.blue == $past(v3_out), "no channel carries the brightness")

endmodule
